[sv/rsc_pkg.sv]
// Shared types and constants for the rectangle subtract-and-clip block.
package rsc_pkg;

  // Coordinate width of every rectangle edge.
  localparam int COORD_BITS = 16;

  // APB register map: word index of each clip register.
  localparam int REG_IDX_BITS = 2;
  localparam int ADDR_BITS = REG_IDX_BITS + 2;
  localparam logic [REG_IDX_BITS-1:0] REG_CLIP_TOP    = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_CLIP_LEFT   = 2'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_CLIP_BOTTOM = 2'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_CLIP_RIGHT  = 2'd3;

  // Most pieces one rectangle can be cut into.
  localparam int MAX_PIECES = 4;

  typedef logic [COORD_BITS-1:0] coord_t;

  // Generic inclusive rectangle.
  typedef struct packed {
    coord_t top;
    coord_t left;
    coord_t bottom;
    coord_t right;
  } rect_t;

  // Input request payload.
  typedef struct packed {
    coord_t in_top;
    coord_t in_left;
    coord_t in_bottom;
    coord_t in_right;
  } rect_req_t;

  // Result payload.
  typedef struct packed {
    coord_t piece_top;
    coord_t piece_left;
    coord_t piece_bottom;
    coord_t piece_right;
    logic   piece_last;
  } piece_t;

  // All pieces of one request, with a mask of those that exist.
  typedef struct packed {
    rect_t [MAX_PIECES-1:0] piece;
    logic  [MAX_PIECES-1:0] mask;
  } cut_t;

endpackage

[sv/rsc_regs.sv]
// APB register file holding the clip rectangle.
module rsc_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rsc_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output rsc_pkg::rect_t                 clip
);
  import rsc_pkg::*;

  logic                    wr_en;
  logic [REG_IDX_BITS-1:0] idx;
  coord_t                  rd_val;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[ADDR_BITS-1:2];

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      clip <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_CLIP_TOP:    clip.top    <= pwdata[COORD_BITS-1:0];
        REG_CLIP_LEFT:   clip.left   <= pwdata[COORD_BITS-1:0];
        REG_CLIP_BOTTOM: clip.bottom <= pwdata[COORD_BITS-1:0];
        REG_CLIP_RIGHT:  clip.right  <= pwdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    case (idx)
      REG_CLIP_TOP:    rd_val = clip.top;
      REG_CLIP_LEFT:   rd_val = clip.left;
      REG_CLIP_BOTTOM: rd_val = clip.bottom;
      REG_CLIP_RIGHT:  rd_val = clip.right;
      default:         rd_val = '0;
    endcase
  end

  assign prdata = 32'(rd_val);

endmodule

[sv/rsc_cut.sv]
// Cut logic: splits one rectangle against the clip into up to four pieces.
module rsc_cut (
  input  rsc_pkg::rect_t rect,
  input  rsc_pkg::rect_t clip,
  output rsc_pkg::cut_t  cut
);
  import rsc_pkg::*;

  logic   overlap;
  logic   cut_l, cut_tp, cut_r, cut_b;
  coord_t lft1, top2, rgt3;

  // Overlap test on inclusive bounds.
  assign overlap = (rect.left <= clip.right) && (rect.right >= clip.left) &&
                   (rect.top <= clip.bottom) && (rect.bottom >= clip.top);

  // Each edge cut narrows the remainder seen by the next one.
  always_comb begin
    cut_l  = (clip.left > rect.left) && (clip.left <= rect.right);
    lft1   = cut_l ? clip.left : rect.left;
    cut_tp = (clip.top > rect.top) && (clip.top <= rect.bottom);
    top2   = cut_tp ? clip.top : rect.top;
    cut_r  = (clip.right >= lft1) && (clip.right < rect.right);
    rgt3   = cut_r ? clip.right : rect.right;
    cut_b  = (clip.bottom >= top2) && (clip.bottom < rect.bottom);
  end

  // Assemble the pieces; a disjoint rectangle passes through whole.
  always_comb begin
    if (!overlap) begin
      cut.piece    = '0;
      cut.piece[0] = rect;
      cut.mask     = 4'b0001;
    end else begin
      cut.piece[0] = '{top: rect.top, left: rect.left, bottom: rect.bottom,
                       right: clip.left - coord_t'(1)};
      cut.piece[1] = '{top: rect.top, left: lft1, bottom: clip.top - coord_t'(1),
                       right: rect.right};
      cut.piece[2] = '{top: top2, left: clip.right + coord_t'(1), bottom: rect.bottom,
                       right: rect.right};
      cut.piece[3] = '{top: clip.bottom + coord_t'(1), left: lft1, bottom: rect.bottom,
                       right: rgt3};
      cut.mask     = {cut_b, cut_r, cut_tp, cut_l};
    end
  end

endmodule

[sv/rsc_out.sv]
// Result register: holds the pieces of one request and hands them out in order.
module rsc_out (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  rsc_pkg::cut_t   cut,
  output logic            free,
  output logic            piece_valid,
  input  logic            piece_ready,
  output rsc_pkg::piece_t piece
);
  import rsc_pkg::*;

  rect_t [MAX_PIECES-1:0] pieces;
  logic  [MAX_PIECES-1:0] mask;
  logic  [MAX_PIECES-1:0] mask_next;
  logic                   last;
  logic                   take;
  rect_t                  sel;

  // Drop the lowest pending piece once it is taken.
  assign mask_next   = mask & (mask - MAX_PIECES'(1));
  assign last        = (mask_next == '0);
  assign piece_valid = (mask != '0);
  assign take        = piece_valid && piece_ready;
  assign free        = !piece_valid || (take && last);

  // Lowest pending piece goes out first.
  always_comb begin
    if (mask[0]) begin
      sel = pieces[0];
    end else if (mask[1]) begin
      sel = pieces[1];
    end else if (mask[2]) begin
      sel = pieces[2];
    end else begin
      sel = pieces[3];
    end
  end

  assign piece = '{piece_top: sel.top, piece_left: sel.left,
                   piece_bottom: sel.bottom, piece_right: sel.right,
                   piece_last: last};

  // Pending mask.
  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (load) begin
      mask <= cut.mask;
    end else if (take) begin
      mask <= mask_next;
    end
  end

  // Piece payload.
  always_ff @(posedge clk) begin
    if (load) begin
      pieces <= cut.piece;
    end
  end

endmodule

[sv/rect_subtract_clip_top.sv]
// Top level of the rectangle subtract-and-clip block.
// A request accepted into the input register moves into the result register as
// soon as that register is free, and its first piece is then offered from there.
// The input register can take a new request while the result register still hands
// out pieces, one piece per cycle on the output port while piece_ready is high.
// Reset (rst, synchronous): clip registers clear to zero, both stages empty.
module rect_subtract_clip_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           rect_valid,
  output logic                           rect_ready,
  input  rsc_pkg::rect_req_t             rect,
  output logic                           piece_valid,
  input  logic                           piece_ready,
  output rsc_pkg::piece_t                piece,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rsc_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import rsc_pkg::*;

  rect_t clip;
  rect_t hold;
  logic  hold_valid;
  logic  free;
  logic  load;
  cut_t  cut;

  rsc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .clip    (clip)
  );

  // Input register: refills as soon as its request moves on.
  assign load       = hold_valid && free;
  assign rect_ready = !hold_valid || free;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (rect_ready) begin
      hold_valid <= rect_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rect_valid && rect_ready) begin
      hold <= '{top: rect.in_top, left: rect.in_left,
                bottom: rect.in_bottom, right: rect.in_right};
    end
  end

  rsc_cut u_cut (
    .rect (hold),
    .clip (clip),
    .cut  (cut)
  );

  rsc_out u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .cut         (cut),
    .free        (free),
    .piece_valid (piece_valid),
    .piece_ready (piece_ready),
    .piece       (piece)
  );

endmodule
